### src/usc_pkg.sv
// ----------------------------------------------------------------------------
// usc_pkg: shared types and constants of the unipolar stepper controller
// Function codes, register indexes, timebase structs, coil and divider tables.
// ----------------------------------------------------------------------------
package usc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned OUT_CNT_W  = 12;

	// last value of the holding PWM counter (counts 0..99)
	localparam logic [6:0] PWM_LAST = 7'd99;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_ADD   = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE       = 3'd0,
		REG_FORWARD      = 3'd1,
		REG_HALF_STEP    = 3'd2,
		REG_CLOCK_SELECT = 3'd3,
		REG_STEP_PERIOD  = 3'd4,
		REG_HOLD_PERCENT = 3'd5
	} reg_idx_t;

	// request into the timebase for the transaction in stage 1
	typedef struct packed {
		logic       tick;
		logic [1:0] clock_select;
		logic [7:0] step_period;
		logic [6:0] hold_percent;
	} tb_req_t;

	// timebase answer for the same transaction
	typedef struct packed {
		logic step_due;
		logic pwm_on;
	} tb_rsp_t;

	function automatic logic [9:0] prescale_div(input logic [1:0] sel);
		logic [9:0] div;
		case (sel)
			2'd0:    div = 10'd1;
			2'd1:    div = 10'd10;
			2'd2:    div = 10'd100;
			default: div = 10'd1000;
		endcase
		return div;
	endfunction

	// half-step sequence ab, b, bc, c, cd, d, da, a (bit0 = coil a)
	function automatic logic [3:0] coil_pattern(input logic [2:0] idx);
		logic [3:0] pat;
		case (idx)
			3'd0:    pat = 4'h3;
			3'd1:    pat = 4'h2;
			3'd2:    pat = 4'h6;
			3'd3:    pat = 4'h4;
			3'd4:    pat = 4'hC;
			3'd5:    pat = 4'h8;
			3'd6:    pat = 4'h9;
			default: pat = 4'h1;
		endcase
		return pat;
	endfunction

endpackage

### src/usc_in_if.sv
// ----------------------------------------------------------------------------
// usc_in_if: input channel of the stepper controller
// Valid/ready channel carrying one tick or count access per transaction.
// ----------------------------------------------------------------------------
interface usc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [11:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

### src/usc_out_if.sv
// ----------------------------------------------------------------------------
// usc_out_if: result channel of the stepper controller
// Valid/ready channel carrying coil drive and count status per transaction.
// ----------------------------------------------------------------------------
interface usc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  coils;
	logic [11:0] remaining;
	logic        moving;
	logic        add_overflow;

	modport source (output valid, output coils, output remaining, output moving,
		output add_overflow, input ready);
	modport sink (input valid, input coils, input remaining, input moving,
		input add_overflow, output ready);
endinterface

### src/usc_timebase.sv
// ----------------------------------------------------------------------------
// usc_timebase: prescaler, step period counter and holding PWM counter
// Advances on tick transactions only; flags a due step and the PWM phase.
// ----------------------------------------------------------------------------
module usc_timebase
	import usc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  tb_req_t req,
	output tb_rsp_t rsp
);

	logic [9:0] prescale_q;
	logic [7:0] period_q;
	logic [6:0] pwm_q;

	logic [9:0] div;
	logic [7:0] per;
	logic       pre_wrap;
	logic       per_wrap;
	logic [6:0] pwm_d;

	always_comb begin
		div = prescale_div(req.clock_select);
		per = (req.step_period == 8'd0) ? 8'd1 : req.step_period;
		// at or past the end also wraps (stale count after a lowered divider)
		pre_wrap = ({1'b0, prescale_q} + 11'd1) >= {1'b0, div};
		per_wrap = ({1'b0, period_q} + 9'd1) >= {1'b0, per};
		if (req.tick) begin
			pwm_d = (pwm_q >= PWM_LAST) ? 7'd0 : pwm_q + 7'd1;
		end else begin
			pwm_d = pwm_q;
		end
		rsp.pwm_on   = pwm_d < req.hold_percent;
		rsp.step_due = req.tick && pre_wrap && per_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			period_q   <= '0;
			pwm_q      <= '0;
		end else if (req.tick) begin
			pwm_q <= pwm_d;
			if (pre_wrap) begin
				prescale_q <= '0;
				period_q   <= per_wrap ? 8'd0 : period_q + 8'd1;
			end else begin
				prescale_q <= prescale_q + 10'd1;
			end
		end
	end

endmodule

### src/unipolar_stepper_controller_unit.sv
// ----------------------------------------------------------------------------
// unipolar_stepper_controller_unit: unipolar stepper motor controller
// Full/half stepping with prescaled step rate, step count and holding PWM.
// ----------------------------------------------------------------------------
// Usage:
//  - items (valid/ready): one transaction is a 1 us tick (func TICK) or a
//    count access: WRITE sets the step count, ADD adds with saturation,
//    READ returns it. value is used by WRITE and ADD only.
//  - results (valid/ready): exactly one result per item: coil drive,
//    remaining steps, moving flag and the add saturation flag.
//  - cfg_we/cfg_idx/cfg_data: register writes, taken on any edge with
//    cfg_we high; write only while no item is in flight.
//  - The result is registered: stage 1 holds the item, the result register
//    holds the answer, and results.valid rises once stage 1 passes it on.
//    One item per cycle is sustained while results are taken; the only
//    loop is the count/phase/timebase update.
//  - When results stalls, the result register holds and stage 1 still
//    takes one more item, then items.ready drops until the result leaves.
//  - Reset clears the counters and loads the register defaults (disabled,
//    i.e. brake with all coils high; forward; full step; 1 ms clock).
// ----------------------------------------------------------------------------
module unipolar_stepper_controller_unit
	import usc_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	usc_in_if.sink                items,
	usc_out_if.source             results
);

	// sum width covers both the count and the 12-bit value plus a carry
	localparam int unsigned SUM_W = ((COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W) + 1;
	localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'((1 << COUNT_BITS) - 1);

	// configuration registers
	logic       enable_q;
	logic       forward_q;
	logic       half_step_q;
	logic [1:0] clock_select_q;
	logic [7:0] step_period_q;
	logic [6:0] hold_percent_q;

	// block state
	logic [COUNT_BITS-1:0] steps_left_q;
	logic [2:0]            phase_q;

	// stage 1: accepted transaction
	logic        valid_s1;
	func_t       func_s1;
	logic [11:0] value_s1;

	// result register
	logic        res_valid_q;
	logic [3:0]  coils_q;
	logic [11:0] remaining_q;
	logic        moving_q;
	logic        ovf_q;

	logic advance;
	logic fire_s1;

	tb_req_t tb_req;
	tb_rsp_t tb_rsp;

	logic [SUM_W-1:0]      value_ext;
	logic [SUM_W-1:0]      steps_ext;
	logic [SUM_W-1:0]      sum;
	logic [SUM_W-1:0]      steps_d_ext;
	logic                  take_step;
	logic [COUNT_BITS-1:0] steps_d;
	logic [2:0]            phase_base;
	logic [2:0]            phase_inc;
	logic [2:0]            phase_d;
	logic [3:0]            pattern;
	logic [3:0]            coils_d;
	logic                  moving_d;
	logic                  ovf_d;

	// ---------------------------------------------------------------- handshake
	// result register empties or drains this cycle -> stage 1 may move on
	assign advance     = !res_valid_q || results.ready;
	assign fire_s1     = valid_s1 && advance;
	assign items.ready = !valid_s1 || advance;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			forward_q      <= 1'b1;
			half_step_q    <= 1'b0;
			clock_select_q <= 2'd3;
			step_period_q  <= 8'd1;
			hold_percent_q <= 7'd0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_ENABLE:       enable_q       <= cfg_data[0];
				REG_FORWARD:      forward_q      <= cfg_data[0];
				REG_HALF_STEP:    half_step_q    <= cfg_data[0];
				REG_CLOCK_SELECT: clock_select_q <= cfg_data[1:0];
				REG_STEP_PERIOD:  step_period_q  <= cfg_data[7:0];
				REG_HOLD_PERCENT: hold_percent_q <= cfg_data[6:0];
				default: ; // unused indexes are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------- timebase
	assign tb_req.tick         = fire_s1 && (func_s1 == FUNC_TICK);
	assign tb_req.clock_select = clock_select_q;
	assign tb_req.step_period  = step_period_q;
	assign tb_req.hold_percent = hold_percent_q;

	usc_timebase u_timebase (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tb_req),
		.rsp    (tb_rsp)
	);

	// ---------------------------------------------------------------- step logic
	always_comb begin
		value_ext = SUM_W'(value_s1);
		steps_ext = SUM_W'(steps_left_q);
		sum       = value_ext + steps_ext;
		take_step = tb_rsp.step_due && enable_q && (steps_left_q != '0);

		// full step snaps to the even (two-coil) state and moves by two
		phase_base = half_step_q ? phase_q : {phase_q[2:1], 1'b0};
		phase_inc  = half_step_q ? 3'd1 : 3'd2;

		steps_d = steps_left_q;
		phase_d = phase_q;
		ovf_d   = 1'b0;
		case (func_s1)
			FUNC_TICK: begin
				if (take_step) begin
					steps_d = steps_left_q - 1'b1;
					phase_d = forward_q ? phase_base + phase_inc : phase_base - phase_inc;
				end
			end
			FUNC_WRITE: begin
				// oversize write clips silently (narrow counts only)
				steps_d = (value_ext > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
					: value_ext[COUNT_BITS-1:0];
			end
			FUNC_ADD: begin
				if (sum > COUNT_MAX) begin
					steps_d = COUNT_MAX[COUNT_BITS-1:0];
					ovf_d   = 1'b1;
				end else begin
					steps_d = sum[COUNT_BITS-1:0];
				end
			end
			default: ; // read leaves state alone
		endcase

		steps_d_ext = SUM_W'(steps_d);
		pattern     = coil_pattern(half_step_q ? phase_d : {phase_d[2:1], 1'b0});
		moving_d    = enable_q && (steps_d != '0);

		// brake when disabled, holding PWM once the count is spent
		if (!enable_q) begin
			coils_d = 4'hF;
		end else if (steps_d != '0 || tb_rsp.pwm_on) begin
			coils_d = pattern;
		end else begin
			coils_d = 4'h0;
		end
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			steps_left_q <= '0;
			phase_q      <= '0;
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (fire_s1) begin
				steps_left_q <= steps_d;
				phase_q      <= phase_d;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			func_s1  <= func_t'(items.func);
			value_s1 <= items.value;
		end
		if (fire_s1) begin
			coils_q     <= coils_d;
			remaining_q <= steps_d_ext[OUT_CNT_W-1:0];
			moving_q    <= moving_d;
			ovf_q       <= ovf_d;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.coils        = coils_q;
	assign results.remaining    = remaining_q;
	assign results.moving       = moving_q;
	assign results.add_overflow = ovf_q;

	// ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
	// a saturating add leaves the count at its maximum
	a_ovf_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && ovf_q |-> steps_left_q == COUNT_MAX[COUNT_BITS-1:0])
		else $error("add_overflow without saturated count");

	// a moving motor always energizes some coil
	a_moving_coils: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && moving_q |-> coils_q != 4'h0)
		else $error("moving with all coils off");

	// bus accesses never move the rotor
	a_phase_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && func_s1 != FUNC_TICK |=> $stable(phase_q))
		else $error("phase changed on a count access");

	// a tick takes at most one step
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && func_s1 == FUNC_TICK |=>
		(steps_left_q == $past(steps_left_q)) ||
		(steps_left_q == COUNT_BITS'($past(steps_left_q) - 1'b1)))
		else $error("tick changed the count by more than one step");
`endif

endmodule

### sim/unipolar_stepper_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// unipolar_stepper_controller_unit_tb: self-checking bench of the stepper unit
// Walks a directed table of count accesses, ticks and register writes, then
// random phases under several flow-control patterns. Every result is checked
// against a typed-in or cycle-free predicted count, phase and holding PWM.
// ----------------------------------------------------------------------------
module unipolar_stepper_controller_unit_tb;
	import usc_pkg::*;

	localparam int unsigned LATENCY         = 2;
	localparam int unsigned CYCLE_LIMIT     = 200000;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned ITEMS_PER_PHASE = 63;
	localparam int unsigned COUNT_MAX       = 4095;
	localparam int unsigned PWM_SPAN        = 100;

	// indexes past the last register: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [3:0] COILS_BRAKE = 4'hF;
	localparam logic [3:0] COILS_OFF   = 4'h0;

	// ticks per period clock, by clock select
	localparam int unsigned DIVIDER[4] = '{1, 10, 100, 1000};
	// half-step sequence ab, b, bc, c, cd, d, da, a (bit0 = coil a)
	localparam logic [3:0] HALF_SEQ[8] = '{4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9, 4'h1};

	typedef struct packed {
		logic [3:0]  coils;
		logic [11:0] remaining;
		logic        moving;
		logic        add_overflow;
	} step_result_t;

	// one line of the directed table: a register write or a transaction,
	// with a typed-in result where it is obvious
	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [7:0]           data;
		func_t                func;
		logic [11:0]          value;
		logic                 known;
		step_result_t         result;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	usc_in_if  item_if ();
	usc_out_if result_if ();

	unipolar_stepper_controller_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.items   (item_if),
		.results (result_if)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor state: register copy and counters, updated per transaction
	// ---------------------------------------------------------------------
	logic       run_en;
	logic       dir_fwd;
	logic       half_mode;
	logic [1:0] clk_sel;
	logic [7:0] step_per;
	logic [6:0] hold_pct;

	logic [9:0]  prescale;
	logic [7:0]  period;
	logic [11:0] count;
	logic [2:0]  phase;
	logic [6:0]  pwm;

	step_result_t expected_results[$];
	stim_row_t    directed_tbl[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned error_cnt;
	int unsigned items_sent;
	int unsigned directed_cnt;
	int unsigned results_seen;
	int unsigned cfg_writes;
	int unsigned steps_taken;
	int unsigned cycle_cnt;

	// Apply one transaction to the predictor and return the result it owes.
	function automatic step_result_t advance_stepper(input func_t f, input logic [11:0] v);
		step_result_t r;
		int unsigned  sum;
		int unsigned  per;
		logic [2:0]   idx;
		logic [3:0]   pat;
		r = '0;
		case (f)
			FUNC_TICK: begin
				// zero period runs like a period of one
				per = (step_per == 8'd0) ? 1 : step_per;
				pwm = (pwm + 1 >= PWM_SPAN) ? 7'd0 : pwm + 7'd1;
				// '<' rather than '!=': a count left past a lowered end
				// completes on the next tick
				if (prescale + 1 < DIVIDER[clk_sel]) begin
					prescale = prescale + 10'd1;
				end else begin
					prescale = '0;
					if (period + 1 < per) begin
						period = period + 8'd1;
					end else begin
						period = '0;
						// braking keeps the counters running but never steps
						if (run_en && count != 12'd0) begin
							if (half_mode)
								phase = dir_fwd ? phase + 3'd1 : phase - 3'd1;
							else
								phase = {phase[2:1], 1'b0} + (dir_fwd ? 3'd2 : 3'd6);
							count = count - 12'd1;
							steps_taken++;
						end
					end
				end
			end
			FUNC_WRITE: count = v;
			FUNC_ADD: begin
				sum = count + v;
				if (sum > COUNT_MAX) begin
					count = COUNT_MAX[11:0];
					r.add_overflow = 1'b1;
				end else begin
					count = sum[11:0];
				end
			end
			default: ;
		endcase
		// full step shows only the two-coil (even) states
		idx = half_mode ? phase : {phase[2:1], 1'b0};
		pat = HALF_SEQ[idx];
		if (!run_en)
			r.coils = COILS_BRAKE;
		else if (count != 12'd0)
			r.coils = pat;
		else
			r.coils = (pwm < hold_pct) ? pat : COILS_OFF;
		r.remaining = count;
		r.moving    = run_en && count != 12'd0;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		stim_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		r.func   = FUNC_TICK;
		return r;
	endfunction

	function automatic stim_row_t item_row(input func_t f, input logic [11:0] v);
		stim_row_t r;
		r       = '0;
		r.func  = f;
		r.value = v;
		return r;
	endfunction

	function automatic stim_row_t known_row(input func_t f, input logic [11:0] v,
		input logic [3:0] coils, input logic [11:0] rem, input logic mov, input logic ovf);
		stim_row_t r;
		r        = item_row(f, v);
		r.known  = 1'b1;
		r.result = '{coils: coils, remaining: rem, moving: mov, add_overflow: ovf};
		return r;
	endfunction

	task automatic report_error(input string what);
		$display("ERROR cycle %0d: %s", cycle_cnt, what);
		error_cnt++;
	endtask

	task automatic check_field(input string name, input logic [11:0] got, input logic [11:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				results_seen, name, got, want));
	endtask

	// Offer one transaction and hold it until accepted; the predictor runs
	// at the accepting edge. valid is left high for a back-to-back follower.
	task automatic send_item(input func_t f, input logic [11:0] v, input logic known,
		input step_result_t known_result);
		step_result_t predicted;
		item_if.valid <= 1'b1;
		item_if.func  <= f;
		item_if.value <= v;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		predicted = advance_stepper(f, v);
		expected_results.push_back(known ? known_result : predicted);
		items_sent++;
	endtask

	// Sender idle cycles after a transaction, geometric with send_idle_pct.
	task automatic idle_gap();
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding result, then the pipe depth.
	task automatic drain();
		item_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// One register write; the spare cycle keeps cfg_we to a single
	// assignment per time step across consecutive writes.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_ENABLE:       run_en    = data[0];
			REG_FORWARD:      dir_fwd   = data[0];
			REG_HALF_STEP:    half_mode = data[0];
			REG_CLOCK_SELECT: clk_sel   = data[1:0];
			REG_STEP_PERIOD:  step_per  = data;
			REG_HOLD_PERCENT: hold_pct  = data[6:0];
			default: ;
		endcase
		cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Result side: random back-pressure and the scoreboard
	// ---------------------------------------------------------------------
	always @(posedge clk)
		result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	step_result_t oldest;

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_error("result with no transaction outstanding");
			end else begin
				oldest = expected_results.pop_front();
				check_field("coils", 12'(result_if.coils), 12'(oldest.coils));
				check_field("remaining", result_if.remaining, oldest.remaining);
				check_field("moving", 12'(result_if.moving), 12'(oldest.moving));
				check_field("add_overflow", 12'(result_if.add_overflow),
					12'(oldest.add_overflow));
			end
		end
	end

	// hard stop well beyond the slowest legal run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, expected_results.size());
			$display("unipolar_stepper_controller_unit_tb failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		stim_row_t  row;
		logic [7:0] d;
		logic [1:0] sel;
		int unsigned r;
		func_t      f;
		logic [11:0] v;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = REG_ENABLE;
		cfg_data        = '0;
		item_if.valid   = 1'b0;
		item_if.func    = FUNC_TICK;
		item_if.value   = '0;
		result_if.ready = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		error_cnt       = 0;
		items_sent      = 0;
		results_seen    = 0;
		cfg_writes      = 0;
		steps_taken     = 0;
		cycle_cnt       = 0;

		// predictor copy of the reset state
		run_en    = 1'b0;
		dir_fwd   = 1'b1;
		half_mode = 1'b0;
		clk_sel   = 2'd3;
		step_per  = 8'd1;
		hold_pct  = 7'd0;
		prescale  = '0;
		period    = '0;
		count     = '0;
		phase     = '0;
		pwm       = '0;

		directed_tbl = '{
			// out of reset: brake, empty count
			known_row(FUNC_READ,  12'd0,    COILS_BRAKE, 12'd0,    1'b0, 1'b0),
			known_row(FUNC_WRITE, 12'd4095, COILS_BRAKE, 12'd4095, 1'b0, 1'b0),
			// add saturation, smallest and largest addend
			known_row(FUNC_ADD,   12'd1,    COILS_BRAKE, 12'd4095, 1'b0, 1'b1),
			known_row(FUNC_ADD,   12'd4095, COILS_BRAKE, 12'd4095, 1'b0, 1'b1),
			known_row(FUNC_WRITE, 12'd0,    COILS_BRAKE, 12'd0,    1'b0, 1'b0),
			// sum landing exactly on the maximum does not flag
			known_row(FUNC_ADD,   12'd4095, COILS_BRAKE, 12'd4095, 1'b0, 1'b0),
			// brake: counters run, no step, value ignored
			known_row(FUNC_TICK,  12'd4095, COILS_BRAKE, 12'd4095, 1'b0, 1'b0),
			cfg_row(REG_SPARE_6, 8'hFF),
			cfg_row(REG_SPARE_7, 8'hFF),
			// 1 us clock with zero period: a step on every tick
			cfg_row(REG_ENABLE, 8'h01),
			cfg_row(REG_CLOCK_SELECT, 8'h00),
			cfg_row(REG_STEP_PERIOD, 8'h00),
			item_row(FUNC_WRITE, 12'd3),
			item_row(FUNC_TICK, 12'd0),
			item_row(FUNC_TICK, 12'hAAA),
			item_row(FUNC_TICK, 12'h555),
			item_row(FUNC_TICK, 12'd0),
			// holding duty above 100 means full holding current
			cfg_row(REG_HOLD_PERCENT, 8'hFF),
			item_row(FUNC_READ, 12'hFFF),
			// reverse half stepping with partial holding
			cfg_row(REG_HALF_STEP, 8'h01),
			cfg_row(REG_FORWARD, 8'h00),
			cfg_row(REG_HOLD_PERCENT, 8'd50),
			item_row(FUNC_WRITE, 12'd2),
			item_row(FUNC_TICK, 12'd0),
			item_row(FUNC_TICK, 12'd0),
			item_row(FUNC_TICK, 12'd0),
			// slowest period, then a lowered clock select and period leave
			// stale counts that the next tick completes
			cfg_row(REG_CLOCK_SELECT, 8'h01),
			cfg_row(REG_STEP_PERIOD, 8'hFF),
			item_row(FUNC_WRITE, 12'd4095),
			item_row(FUNC_TICK, 12'd0),
			item_row(FUNC_TICK, 12'd0),
			item_row(FUNC_TICK, 12'd0),
			cfg_row(REG_CLOCK_SELECT, 8'h00),
			item_row(FUNC_TICK, 12'd0),
			item_row(FUNC_TICK, 12'd0),
			item_row(FUNC_TICK, 12'd0),
			cfg_row(REG_STEP_PERIOD, 8'h02),
			item_row(FUNC_TICK, 12'd0),
			// back to brake with steps left
			cfg_row(REG_ENABLE, 8'h00),
			item_row(FUNC_TICK, 12'd0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk: no idling on either side
		foreach (directed_tbl[i]) begin
			row = directed_tbl[i];
			if (row.is_cfg) begin
				drain();
				write_reg(row.idx, row.data);
			end else begin
				send_item(row.func, row.value, row.known, row.result);
			end
		end
		directed_cnt = items_sent;

		// random phases: idle pattern cycles none/sender/receiver/both
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase

			// mostly enabled and fast enough to step; upper data bits random
			d    = 8'($urandom);
			d[0] = ($urandom_range(0, 7) != 0);
			write_reg(REG_ENABLE, d);
			write_reg(REG_FORWARD, 8'($urandom));
			write_reg(REG_HALF_STEP, 8'($urandom));
			if (ph == 5)
				sel = 2'd2;
			else if (ph == 6)
				sel = 2'd3;
			else
				sel = 2'($urandom_range(0, 1));
			d      = 8'($urandom);
			d[1:0] = sel;
			write_reg(REG_CLOCK_SELECT, d);
			if (ph == 3)
				d = 8'hFF;
			else if (ph == 6)
				d = 8'h01;
			else
				d = 8'($urandom_range(0, 5));
			write_reg(REG_STEP_PERIOD, d);
			if (ph == 0)
				d = 8'd100;
			else if (ph == 1)
				d = 8'd0;
			else
				d = 8'($urandom);
			write_reg(REG_HOLD_PERCENT, d);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// mid-phase hold-off until the pipe is empty
				if (n == ITEMS_PER_PHASE / 2)
					drain();
				r = $urandom_range(0, 99);
				if (r < 70)
					f = FUNC_TICK;
				else if (r < 82)
					f = FUNC_WRITE;
				else if (r < 92)
					f = FUNC_ADD;
				else
					f = FUNC_READ;
				// small counts so runs end and holding gets exercised
				r = $urandom_range(0, 9);
				if (f == FUNC_TICK || f == FUNC_READ || r < 4)
					v = 12'($urandom_range(0, 4095));
				else if (r == 4)
					v = 12'd4095;
				else
					v = 12'($urandom_range(0, 12));
				send_item(f, v, 1'b0, '0);
				idle_gap();
			end
		end

		// flush and watch a little longer for stray results
		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (expected_results.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_results.size()));

		$display("summary: %0d transactions (%0d directed), %0d results checked, %0d reg writes",
			items_sent, directed_cnt, results_seen, cfg_writes);
		$display("summary: %0d motor steps over %0d random phases, %0d errors",
			steps_taken, PHASES, error_cnt);
		if (error_cnt == 0)
			$display("unipolar_stepper_controller_unit_tb passed");
		else
			$display("unipolar_stepper_controller_unit_tb failed");
		$finish;
	end

endmodule

### sim.f
src/usc_pkg.sv
src/usc_in_if.sv
src/usc_out_if.sv
src/usc_timebase.sv
src/unipolar_stepper_controller_unit.sv
sim/unipolar_stepper_controller_unit_tb.sv
